@@ rtl/lr_pkg.sv @@
// Line rasterizer package: request codes and the color payload width.
// No dependencies; used by the interfaces and line_rasterizer.
`default_nettype none

package lr_pkg;

    localparam int COLOR_BITS = 24;

    typedef enum logic [0:0] {
        OP_BEGIN = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

endpackage

`default_nettype wire

@@ rtl/lr_req_if.sv @@
// Request channel of the line rasterizer: valid/ready plus line request payload.
// Depends on lr_pkg.
`default_nettype none

interface lr_req_if #(
    parameter int COORD_BITS = 10
);
    logic                          valid;
    logic                          ready;
    lr_pkg::opcode_t               opcode;
    logic [COORD_BITS-1:0]         start_x;
    logic [COORD_BITS-1:0]         start_y;
    logic [COORD_BITS-1:0]         end_x;
    logic [COORD_BITS-1:0]         end_y;
    logic [lr_pkg::COLOR_BITS-1:0] line_color;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y, line_color,
        input  ready
    );

    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y, line_color,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/lr_pix_if.sv @@
// Pixel channel of the line rasterizer: valid/ready plus pixel payload.
// Depends on lr_pkg.
`default_nettype none

interface lr_pix_if #(
    parameter int COORD_BITS = 10
);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         pixel_x;
    logic [COORD_BITS-1:0]         pixel_y;
    logic [lr_pkg::COLOR_BITS-1:0] pixel_color;
    logic                          last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/line_rasterizer.sv @@
// Bresenham line rasterizer top level: request register, line state, pixel register.
// Depends on lr_pkg, lr_req_if, lr_pix_if, lr_setup and lr_step.
//
// Usage:
//   line_in carries requests. OP_BEGIN loads two endpoints and a color and
//   yields the first pixel; OP_STEP yields the next pixel of the active line.
//   A begin replaces any active line. A step with no active line is consumed
//   and yields nothing. last_pixel marks the end point; the line then goes idle.
//   pixel_out carries one pixel per producing request.
// Timing:
//   One request per cycle is sustained while pixel_out.ready stays high. A
//   request is held in the request register, then setup or step logic writes
//   line state and the pixel register, which drives pixel_out directly.
//   The setup/step logic between these two registers sets the clock rate.
// Reset:
//   rst_n low clears both valid flags and the line state; no line is active.
// Stall:
//   While pixel_out.ready is low and a pixel is held, the request register
//   holds its request and line_in.ready drops once it is full.
`default_nettype none

module line_rasterizer #(
    parameter int COORD_BITS = 10
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lr_req_if.sink    line_in,
    lr_pix_if.source  pixel_out
);

    localparam int CB  = COORD_BITS;
    localparam int CLR = lr_pkg::COLOR_BITS;

    logic                  req_valid_reg;
    lr_pkg::opcode_t       req_opcode_reg;
    logic [CB-1:0]         req_start_x_reg;
    logic [CB-1:0]         req_start_y_reg;
    logic [CB-1:0]         req_end_x_reg;
    logic [CB-1:0]         req_end_y_reg;
    logic [CLR-1:0]        req_color_reg;

    logic                  active_reg;
    logic                  swapped_reg;
    logic [CB-1:0]         main_pos_reg;
    logic [CB-1:0]         main_end_reg;
    logic [CB-1:0]         minor_pos_reg;
    logic                  minor_neg_reg;
    logic [CB-1:0]         main_delta_reg;
    logic [CB-1:0]         minor_delta_reg;
    logic signed [CB+1:0]  error_reg;
    logic [CLR-1:0]        color_reg;

    logic                  active_next;
    logic                  swapped_next;
    logic [CB-1:0]         main_pos_next;
    logic [CB-1:0]         main_end_next;
    logic [CB-1:0]         minor_pos_next;
    logic                  minor_neg_next;
    logic [CB-1:0]         main_delta_next;
    logic [CB-1:0]         minor_delta_next;
    logic signed [CB+1:0]  error_next;
    logic [CLR-1:0]        color_next;

    logic                  pix_valid_reg;
    logic [CB-1:0]         pix_x_reg;
    logic [CB-1:0]         pix_y_reg;
    logic [CLR-1:0]        pix_color_reg;
    logic                  pix_last_reg;
    logic                  pix_valid_next;

    logic                  out_free;
    logic                  advance;
    logic                  produce;
    logic                  is_begin;
    logic                  last;

    logic                  su_swapped;
    logic [CB-1:0]         su_main_pos;
    logic [CB-1:0]         su_main_end;
    logic [CB-1:0]         su_minor_pos;
    logic                  su_minor_neg;
    logic [CB-1:0]         su_main_delta;
    logic [CB-1:0]         su_minor_delta;
    logic signed [CB+1:0]  su_error;

    logic [CB-1:0]         st_main_pos;
    logic [CB-1:0]         st_minor_pos;
    logic signed [CB+1:0]  st_error;

    lr_setup #(
        .COORD_BITS (CB)
    ) u_setup (
        .start_x     (req_start_x_reg),
        .start_y     (req_start_y_reg),
        .end_x       (req_end_x_reg),
        .end_y       (req_end_y_reg),
        .swapped     (su_swapped),
        .main_pos    (su_main_pos),
        .main_end    (su_main_end),
        .minor_pos   (su_minor_pos),
        .minor_neg   (su_minor_neg),
        .main_delta  (su_main_delta),
        .minor_delta (su_minor_delta),
        .error       (su_error)
    );

    lr_step #(
        .COORD_BITS (CB)
    ) u_step (
        .main_pos       (main_pos_reg),
        .minor_pos      (minor_pos_reg),
        .minor_neg      (minor_neg_reg),
        .main_delta     (main_delta_reg),
        .minor_delta    (minor_delta_reg),
        .error          (error_reg),
        .step_main_pos  (st_main_pos),
        .step_minor_pos (st_minor_pos),
        .step_error     (st_error)
    );

    assign out_free      = !pix_valid_reg || pixel_out.ready;
    assign advance       = req_valid_reg && out_free;
    assign line_in.ready = !req_valid_reg || out_free;
    assign is_begin      = (req_opcode_reg == lr_pkg::OP_BEGIN);

    always_comb
    begin
        swapped_next     = swapped_reg;
        main_pos_next    = main_pos_reg;
        main_end_next    = main_end_reg;
        minor_pos_next   = minor_pos_reg;
        minor_neg_next   = minor_neg_reg;
        main_delta_next  = main_delta_reg;
        minor_delta_next = minor_delta_reg;
        error_next       = error_reg;
        color_next       = color_reg;
        produce          = 1'b0;

        if (advance)
        begin
            if (is_begin)
            begin
                swapped_next     = su_swapped;
                main_pos_next    = su_main_pos;
                main_end_next    = su_main_end;
                minor_pos_next   = su_minor_pos;
                minor_neg_next   = su_minor_neg;
                main_delta_next  = su_main_delta;
                minor_delta_next = su_minor_delta;
                error_next       = su_error;
                color_next       = req_color_reg;
                produce          = 1'b1;
            end
            else if (active_reg)
            begin
                main_pos_next  = st_main_pos;
                minor_pos_next = st_minor_pos;
                error_next     = st_error;
                produce        = 1'b1;
            end
        end

        last        = (main_pos_next == main_end_next);
        active_next = produce ? !last : active_reg;

        if (produce)
        begin
            pix_valid_next = 1'b1;
        end
        else if (pixel_out.ready)
        begin
            pix_valid_next = 1'b0;
        end
        else
        begin
            pix_valid_next = pix_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg   <= 1'b0;
            pix_valid_reg   <= 1'b0;
            active_reg      <= 1'b0;
            swapped_reg     <= 1'b0;
            main_pos_reg    <= '0;
            main_end_reg    <= '0;
            minor_pos_reg   <= '0;
            minor_neg_reg   <= 1'b0;
            main_delta_reg  <= '0;
            minor_delta_reg <= '0;
            error_reg       <= '0;
            color_reg       <= '0;
        end
        else
        begin
            if (line_in.ready)
            begin
                req_valid_reg <= line_in.valid;
            end
            pix_valid_reg   <= pix_valid_next;
            active_reg      <= active_next;
            swapped_reg     <= swapped_next;
            main_pos_reg    <= main_pos_next;
            main_end_reg    <= main_end_next;
            minor_pos_reg   <= minor_pos_next;
            minor_neg_reg   <= minor_neg_next;
            main_delta_reg  <= main_delta_next;
            minor_delta_reg <= minor_delta_next;
            error_reg       <= error_next;
            color_reg       <= color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_in.ready && line_in.valid)
        begin
            req_opcode_reg  <= line_in.opcode;
            req_start_x_reg <= line_in.start_x;
            req_start_y_reg <= line_in.start_y;
            req_end_x_reg   <= line_in.end_x;
            req_end_y_reg   <= line_in.end_y;
            req_color_reg   <= line_in.line_color;
        end
        if (produce)
        begin
            pix_x_reg     <= swapped_next ? minor_pos_next : main_pos_next;
            pix_y_reg     <= swapped_next ? main_pos_next : minor_pos_next;
            pix_color_reg <= color_next;
            pix_last_reg  <= last;
        end
    end

    assign pixel_out.valid       = pix_valid_reg;
    assign pixel_out.pixel_x     = pix_x_reg;
    assign pixel_out.pixel_y     = pix_y_reg;
    assign pixel_out.pixel_color = pix_color_reg;
    assign pixel_out.last_pixel  = pix_last_reg;

endmodule

`default_nettype wire

@@ rtl/lr_setup.sv @@
// Line setup: picks the main axis, orders endpoints, derives deltas and error.
// Purely combinational; no package use.
`default_nettype none

module lr_setup #(
    parameter int COORD_BITS = 10
) (
    input  wire logic [COORD_BITS-1:0]        start_x,
    input  wire logic [COORD_BITS-1:0]        start_y,
    input  wire logic [COORD_BITS-1:0]        end_x,
    input  wire logic [COORD_BITS-1:0]        end_y,
    output logic                              swapped,
    output logic [COORD_BITS-1:0]             main_pos,
    output logic [COORD_BITS-1:0]             main_end,
    output logic [COORD_BITS-1:0]             minor_pos,
    output logic                              minor_neg,
    output logic [COORD_BITS-1:0]             main_delta,
    output logic [COORD_BITS-1:0]             minor_delta,
    output logic signed [COORD_BITS+1:0]      error
);

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] a0;
    logic [COORD_BITS-1:0] a1;
    logic [COORD_BITS-1:0] b0;
    logic [COORD_BITS-1:0] b1;
    logic [COORD_BITS-1:0] first_minor;
    logic [COORD_BITS-1:0] last_minor;
    logic                  reorder;

    always_comb
    begin
        dx      = (end_x > start_x) ? end_x - start_x : start_x - end_x;
        dy      = (end_y > start_y) ? end_y - start_y : start_y - end_y;
        swapped = (dy > dx);
        a0      = swapped ? start_y : start_x;
        b0      = swapped ? start_x : start_y;
        a1      = swapped ? end_y   : end_x;
        b1      = swapped ? end_x   : end_y;
        reorder = (a0 > a1);

        main_pos    = reorder ? a1 : a0;
        main_end    = reorder ? a0 : a1;
        first_minor = reorder ? b1 : b0;
        last_minor  = reorder ? b0 : b1;
        minor_pos   = first_minor;

        main_delta  = main_end - main_pos;
        minor_delta = (last_minor > first_minor) ? last_minor - first_minor
                                                 : first_minor - last_minor;
        minor_neg   = !(first_minor < last_minor);
        error       = $signed({3'b000, main_delta[COORD_BITS-1:1]});
    end

endmodule

`default_nettype wire

@@ rtl/lr_step.sv @@
// Bresenham step: updates error, minor and main coordinates for one pixel.
// Purely combinational; no package use.
`default_nettype none

module lr_step #(
    parameter int COORD_BITS = 10
) (
    input  wire logic [COORD_BITS-1:0]        main_pos,
    input  wire logic [COORD_BITS-1:0]        minor_pos,
    input  wire logic                         minor_neg,
    input  wire logic [COORD_BITS-1:0]        main_delta,
    input  wire logic [COORD_BITS-1:0]        minor_delta,
    input  wire logic signed [COORD_BITS+1:0] error,
    output logic [COORD_BITS-1:0]             step_main_pos,
    output logic [COORD_BITS-1:0]             step_minor_pos,
    output logic signed [COORD_BITS+1:0]      step_error
);

    localparam logic [COORD_BITS-1:0] COORD_ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

    logic signed [COORD_BITS+1:0] error_sub;

    always_comb
    begin
        error_sub = error - $signed({2'b00, minor_delta});
        if (error_sub < 0)
        begin
            step_minor_pos = minor_neg ? minor_pos - COORD_ONE : minor_pos + COORD_ONE;
            step_error     = error_sub + $signed({2'b00, main_delta});
        end
        else
        begin
            step_minor_pos = minor_pos;
            step_error     = error_sub;
        end
        step_main_pos = main_pos + COORD_ONE;
    end

endmodule

`default_nettype wire
